FILE: sv/clipped_font_glyph_blitter_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the clipped font glyph blitter
// Shared property shapes used by the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_FONT_GLYPH_BLITTER_UNIT_DEFINES_SVH
`define CLIPPED_FONT_GLYPH_BLITTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CFGB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfgb check failed");

// Next-cycle implication, disabled while reset is held.
`define CFGB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfgb check failed");

`endif

FILE: sv/cfgb_pkg.sv
// ----------------------------------------------------------------------------
// cfgb_pkg
// Types, constants and the 3x5 font ROM shared by the glyph blitter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cfgb_pkg;

  // Fixed geometry of the font cell and the pen.
  localparam int CELL_W       = 3;
  localparam int CELL_H       = 5;
  localparam int PEN_STEP     = 4;
  localparam int FIRST_CODE   = 33;
  localparam int ROM_SIZE     = 94;
  localparam int GLYPH_COUNT  = 94;
  localparam int FB_ADDR_BITS = 20;
  localparam int PIX_ADDR_W   = 20;
  localparam int QUEUE_DEPTH  = 4;

  // Address mask: the framebuffer address width, then the result field width.
  localparam logic [PIX_ADDR_W-1:0] PIX_ADDR_MASK =
    (FB_ADDR_BITS >= PIX_ADDR_W) ? {PIX_ADDR_W{1'b1}} :
    PIX_ADDR_W'((64'd1 << FB_ADDR_BITS) - 64'd1);

  // Reset values of the configuration registers.
  localparam logic [10:0] FB_WIDTH_RST    = 11'd128;
  localparam logic [10:0] FB_HEIGHT_RST   = 11'd64;
  localparam logic [10:0] LINE_STRIDE_RST = 11'd128;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_SRC_OFFSET_X = 3'd0,
    REG_SRC_OFFSET_Y = 3'd1,
    REG_FB_WIDTH     = 3'd2,
    REG_FB_HEIGHT    = 3'd3,
    REG_LINE_STRIDE  = 3'd4
  } cfg_reg_e;

  // Input transaction payload.
  typedef struct packed {
    logic [7:0] char_code;
    logic       string_start;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [PIX_ADDR_W-1:0] pixel_addr;
    logic                  pixel_on;
    logic                  last_pixel;
  } out_item_t;

  // Live configuration seen by the front and back ends.
  typedef struct packed {
    logic signed [15:0] src_offset_x;
    logic signed [15:0] src_offset_y;
    logic [10:0]        fb_width;
    logic [10:0]        fb_height;
    logic [10:0]        line_stride;
  } cfg_t;

  // One classified character: glyph, visible row/column window, first address.
  typedef struct packed {
    logic [14:0]           glyph;
    logic [2:0]            first_row;
    logic [2:0]            last_row;
    logic [1:0]            first_col;
    logic [1:0]            last_col;
    logic [PIX_ADDR_W-1:0] addr;
  } q_entry_t;

  // Glyph bitmaps, bit index row*3+column, for codes 33 upward.
  localparam logic [14:0] FONT_ROM [0:ROM_SIZE-1] = '{
    15'h4124, 15'h002D, 15'h5F7D, 15'h7DDF, 15'h52A5, 15'h73CB, 15'h0024, 15'h4494,
    15'h2922, 15'h0155, 15'h05D0, 15'h4C00, 15'h01C0, 15'h4000, 15'h12A4, 15'h2B6A,
    15'h749A, 15'h72A3, 15'h79A7, 15'h49ED, 15'h39CF, 15'h7BCE, 15'h12A7, 15'h7BEF,
    15'h39EF, 15'h0820, 15'h4C20, 15'h4454, 15'h0E38, 15'h1511, 15'h21A7, 15'h736F,
    15'h5BEF, 15'h3AEB, 15'h624E, 15'h3B6B, 15'h73CF, 15'h13CF, 15'h6B4E, 15'h5BED,
    15'h7497, 15'h7B24, 15'h5AED, 15'h7249, 15'h5B7D, 15'h5B6F, 15'h7B6F, 15'h13EF,
    15'h76DB, 15'h5AEB, 15'h388E, 15'h2497, 15'h7B6D, 15'h3B6D, 15'h5F6D, 15'h5AAD,
    15'h25ED, 15'h72A7, 15'h6496, 15'h4889, 15'h6926, 15'h016A, 15'h7000, 15'h0022,
    15'h7BE7, 15'h7BC9, 15'h73C0, 15'h7BE4, 15'h73EF, 15'h25D6, 15'h79FC, 15'h5BC9,
    15'h4904, 15'h7904, 15'h5749, 15'h6493, 15'h5FC0, 15'h5BC0, 15'h7BC0, 15'h1F78,
    15'h4F78, 15'h13C0, 15'h7CF8, 15'h24BA, 15'h7B40, 15'h3B40, 15'h7F40, 15'h5540,
    15'h79ED, 15'h77B8, 15'h6456, 15'h4924, 15'h3513, 15'h001E
  };

  // Glyph for a character code; codes without a ROM entry are blank.
  function automatic logic [14:0] glyph_lookup(input logic [7:0] code);
    logic [7:0]  idx;
    logic [14:0] bits;
    idx  = code - 8'(FIRST_CODE);
    bits = '0;
    if ((code >= 8'(FIRST_CODE)) && (idx < 8'(GLYPH_COUNT)) && (idx < 8'(ROM_SIZE))) begin
      bits = FONT_ROM[idx[6:0]];
    end
    return bits;
  endfunction

endpackage

`default_nettype wire

FILE: sv/cfgb_front.sv
// ----------------------------------------------------------------------------
// cfgb_front
// Accepts characters, tracks the pen column, looks up the glyph and clips the
// cell against the framebuffer, then queues the visible window.
// ----------------------------------------------------------------------------
`default_nettype none

module cfgb_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire cfgb_pkg::in_item_t in_data,
  input  wire cfgb_pkg::cfg_t     cfg,
  input  wire logic               q_full,
  output logic                    q_push,
  output cfgb_pkg::q_entry_t      q_wdata
);

  // Pen and stage registers.
  logic [15:0]               pen_r, pen_nxt;
  logic                      s1_valid_r, s2_valid_r, s3_valid_r;
  logic [14:0]               s1_glyph_r, s2_glyph_r;
  logic signed [17:0]        s1_col0_r, s1_row0_r;
  logic [4:0]                s2_rowmask_r;
  logic [2:0]                s2_colmask_r;
  logic [cfgb_pkg::PIX_ADDR_W-1:0] s2_base_r;
  logic                      s3_vis_r;
  cfgb_pkg::q_entry_t        s3_entry_r;

  logic                      accept, adv, stall;
  logic [15:0]               pen_eff;
  logic signed [17:0]        col0_nxt, row0_nxt;
  logic [4:0]                rowmask_nxt;
  logic [2:0]                colmask_nxt;
  logic signed [29:0]        row_prod;
  logic [cfgb_pkg::PIX_ADDR_W-1:0] base_nxt;
  logic [2:0]                fi, li;
  logic [1:0]                fj, lj;
  cfgb_pkg::q_entry_t        entry_nxt;
  logic                      vis_nxt;

  // The pipeline holds only when a visible character waits on a full queue.
  assign stall   = s3_valid_r && s3_vis_r && q_full;
  assign adv     = !stall;
  assign in_full = stall;
  assign accept  = in_push && !stall;
  assign q_push  = s3_valid_r && s3_vis_r && !q_full;
  assign q_wdata = s3_entry_r;

  // Stage 1: pen update, glyph lookup and cell origin.
  always_comb begin
    pen_eff  = in_data.string_start ? 16'd0 : pen_r;
    pen_nxt  = pen_eff + 16'(cfgb_pkg::PEN_STEP);
    col0_nxt = $signed({2'b00, pen_eff}) -
               $signed({{2{cfg.src_offset_x[15]}}, cfg.src_offset_x});
    row0_nxt = 18'sd0 - $signed({{2{cfg.src_offset_y[15]}}, cfg.src_offset_y});
  end

  // Stage 2: row and column visibility, and the address of the cell origin.
  always_comb begin
    logic signed [17:0] r;
    logic signed [17:0] c;
    for (int i = 0; i < cfgb_pkg::CELL_H; i++) begin
      r = s1_row0_r + 18'(i);
      rowmask_nxt[i] = !r[17] && (r[16:0] < {6'b0, cfg.fb_height});
    end
    for (int j = 0; j < cfgb_pkg::CELL_W; j++) begin
      c = s1_col0_r + 18'(j);
      colmask_nxt[j] = !c[17] && (c[16:0] < {6'b0, cfg.fb_width});
    end
    row_prod = s1_row0_r * $signed({1'b0, cfg.line_stride});
    base_nxt = row_prod[cfgb_pkg::PIX_ADDR_W-1:0] +
               cfgb_pkg::PIX_ADDR_W'({{2{s1_col0_r[17]}}, s1_col0_r});
  end

  // Stage 3: the visible window is contiguous; find its corners.
  always_comb begin
    fi = 3'd0;
    li = 3'd0;
    fj = 2'd0;
    lj = 2'd0;
    for (int i = cfgb_pkg::CELL_H - 1; i >= 0; i--) begin
      if (s2_rowmask_r[i]) begin
        fi = 3'(i);
      end
    end
    for (int i = 0; i < cfgb_pkg::CELL_H; i++) begin
      if (s2_rowmask_r[i]) begin
        li = 3'(i);
      end
    end
    for (int j = cfgb_pkg::CELL_W - 1; j >= 0; j--) begin
      if (s2_colmask_r[j]) begin
        fj = 2'(j);
      end
    end
    for (int j = 0; j < cfgb_pkg::CELL_W; j++) begin
      if (s2_colmask_r[j]) begin
        lj = 2'(j);
      end
    end
    vis_nxt             = (s2_rowmask_r != 5'd0) && (s2_colmask_r != 3'd0);
    entry_nxt.glyph     = s2_glyph_r;
    entry_nxt.first_row = fi;
    entry_nxt.last_row  = li;
    entry_nxt.first_col = fj;
    entry_nxt.last_col  = lj;
    entry_nxt.addr      = s2_base_r +
                          cfgb_pkg::PIX_ADDR_W'(fi) *
                          cfgb_pkg::PIX_ADDR_W'(cfg.line_stride) +
                          cfgb_pkg::PIX_ADDR_W'(fj);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r      <= 16'd0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        pen_r <= pen_nxt;
      end
      if (adv) begin
        s1_valid_r <= accept;
        s2_valid_r <= s1_valid_r;
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  // Payload stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_glyph_r   <= cfgb_pkg::glyph_lookup(in_data.char_code);
      s1_col0_r    <= col0_nxt;
      s1_row0_r    <= row0_nxt;
      s2_glyph_r   <= s1_glyph_r;
      s2_rowmask_r <= rowmask_nxt;
      s2_colmask_r <= colmask_nxt;
      s2_base_r    <= base_nxt;
      s3_vis_r     <= vis_nxt;
      s3_entry_r   <= entry_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/cfgb_queue.sv
// ----------------------------------------------------------------------------
// cfgb_queue
// Small first-in first-out buffer between the classifier and the pixel writer.
// ----------------------------------------------------------------------------
`default_nettype none

module cfgb_queue #(
  parameter int QDEPTH = cfgb_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire cfgb_pkg::q_entry_t wdata,
  output logic                    full,
  input  wire logic               pop,
  output cfgb_pkg::q_entry_t      rdata,
  output logic                    empty
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  cfgb_pkg::q_entry_t mem_r [QDEPTH];
  logic [PW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]      count_r;

  assign full  = (count_r == CW'(QDEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: sv/cfgb_back.sv
// ----------------------------------------------------------------------------
// cfgb_back
// Walks the visible window of each queued character and issues one pixel
// write per cycle through an output register, while that register is empty or popped.
// ----------------------------------------------------------------------------
`default_nettype none

module cfgb_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfgb_pkg::cfg_t     cfg,
  input  wire cfgb_pkg::q_entry_t q_rdata,
  input  wire logic               q_empty,
  output logic                    q_pop,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output cfgb_pkg::out_item_t     out_data
);

  localparam int AW = cfgb_pkg::PIX_ADDR_W;

  // Pixel walker and output register.
  logic                gen_valid_r;
  logic [14:0]         glyph_r;
  logic [2:0]          gy_r, last_row_r;
  logic [1:0]          gx_r, first_col_r, last_col_r;
  logic [AW-1:0]       addr_r, row_addr_r;
  logic                out_valid_r;
  cfgb_pkg::out_item_t out_data_r;

  logic                out_adv, fire, gen_last, load;
  logic [3:0]          bit_idx;
  logic [AW-1:0]       next_row_addr;

  assign out_adv       = !out_valid_r || out_pop;
  assign gen_last      = (gy_r == last_row_r) && (gx_r == last_col_r);
  assign fire          = gen_valid_r && out_adv;
  assign load          = !q_empty && (!gen_valid_r || (fire && gen_last));
  assign q_pop         = load;
  assign bit_idx       = {gy_r, 1'b0} + {1'b0, gy_r} + {2'b00, gx_r};
  assign next_row_addr = row_addr_r + AW'(cfg.line_stride);
  assign out_empty     = !out_valid_r;
  assign out_data      = out_data_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        gen_valid_r <= 1'b1;
      end else if (fire && gen_last) begin
        gen_valid_r <= 1'b0;
      end
      if (out_adv) begin
        out_valid_r <= gen_valid_r;
      end
    end
  end

  // Walker position: left to right, then down one row.
  always_ff @(posedge clk) begin
    if (load) begin
      glyph_r     <= q_rdata.glyph;
      gy_r        <= q_rdata.first_row;
      gx_r        <= q_rdata.first_col;
      first_col_r <= q_rdata.first_col;
      last_row_r  <= q_rdata.last_row;
      last_col_r  <= q_rdata.last_col;
      addr_r      <= q_rdata.addr;
      row_addr_r  <= q_rdata.addr;
    end else if (fire) begin
      if (gx_r == last_col_r) begin
        gy_r       <= gy_r + 3'd1;
        gx_r       <= first_col_r;
        row_addr_r <= next_row_addr;
        addr_r     <= next_row_addr;
      end else begin
        gx_r   <= gx_r + 2'd1;
        addr_r <= addr_r + AW'(1);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r.pixel_addr <= addr_r & cfgb_pkg::PIX_ADDR_MASK;
      out_data_r.pixel_on   <= glyph_r[bit_idx];
      out_data_r.last_pixel <= gen_last;
    end
  end

endmodule

`default_nettype wire

FILE: sv/clipped_font_glyph_blitter_unit.sv
// ----------------------------------------------------------------------------
// clipped_font_glyph_blitter_unit
// An accepted character passes the front-end stage registers, the queue and
// the walker before its output register puts the first pixel write on the ports.
// Throughput: one pixel write per cycle from the back-end walker while the result
// register is empty or popped; a character with n visible pixels (1 to 15) gives n.
// Reset: synchronous, active low; clears pen column, queue and valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

`include "clipped_font_glyph_blitter_unit_defines.svh"

module clipped_font_glyph_blitter_unit #(
  parameter int QDEPTH = cfgb_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire cfgb_pkg::in_item_t  in_data,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output cfgb_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [15:0]         cfg_wdata
);

  cfgb_pkg::cfg_t     cfg_r;
  logic               q_push, q_pop, q_full, q_empty;
  cfgb_pkg::q_entry_t q_wdata, q_rdata;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_offset_x <= 16'sd0;
      cfg_r.src_offset_y <= 16'sd0;
      cfg_r.fb_width     <= cfgb_pkg::FB_WIDTH_RST;
      cfg_r.fb_height    <= cfgb_pkg::FB_HEIGHT_RST;
      cfg_r.line_stride  <= cfgb_pkg::LINE_STRIDE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cfgb_pkg::REG_SRC_OFFSET_X: cfg_r.src_offset_x <= $signed(cfg_wdata);
        cfgb_pkg::REG_SRC_OFFSET_Y: cfg_r.src_offset_y <= $signed(cfg_wdata);
        cfgb_pkg::REG_FB_WIDTH:     cfg_r.fb_width     <= cfg_wdata[10:0];
        cfgb_pkg::REG_FB_HEIGHT:    cfg_r.fb_height    <= cfg_wdata[10:0];
        cfgb_pkg::REG_LINE_STRIDE:  cfg_r.line_stride  <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // Front end: accept and classify.
  cfgb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .cfg     (cfg_r),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  // Decoupling queue.
  cfgb_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Back end: pixel writes.
  cfgb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_rdata   (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  // The queue is never written when full nor read when empty, and the front
  // end only holds off new characters because the queue is full.
  `CFGB_ASSERT_IMPL(a_no_push_full, clk, rst_n, q_push, !q_full)
  `CFGB_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, q_pop, !q_empty)
  `CFGB_ASSERT_IMPL(a_stall_cause, clk, rst_n, in_full, q_full)

endmodule

`default_nettype wire
